/* rtl/tournament_branch_predictor_assert.svh */
// Assertion helpers for the tournament branch predictor.
// Each macro expects clk and arst_n in scope.
`ifndef TOURNAMENT_BRANCH_PREDICTOR_ASSERT_SVH
`define TOURNAMENT_BRANCH_PREDICTOR_ASSERT_SVH

// Same-cycle implication
`define TBP_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tbp assertion failed");

// Next-cycle implication
`define TBP_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tbp assertion failed");

`endif

/* rtl/tbp_pkg.sv */
`timescale 1ns / 1ps
package tbp_pkg;

	// Default table geometry
	localparam int GHR_WIDTH  = 9;
	localparam int LHR_WIDTH  = 10;
	localparam int SLOT_WIDTH = 10;

	// Counter value after reset: weakly not taken / weakly favor global
	localparam logic [1:0] CTR_RESET = 2'd1;
	localparam logic [1:0] CTR_MAX   = 2'd3;
	localparam logic [1:0] CTR_MIN   = 2'd0;

	typedef struct packed {
		logic [31:0] branch_pc;
		logic        taken;
	} tbp_req_t;

	typedef struct packed {
		logic predict_taken;
		logic local_guess;
		logic global_guess;
	} tbp_resp_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD1,
		ST_RD2
	} tbp_state_t;

	// 2-bit saturating counter step
	function automatic logic [1:0] sat_move(input logic [1:0] c, input logic up);
		logic [1:0] r;
		r = c;
		if (up) begin
			if (c != CTR_MAX) r = c + 2'd1;
		end else begin
			if (c != CTR_MIN) r = c - 2'd1;
		end
		return r;
	endfunction

endpackage

/* rtl/tbp_ram.sv */
`timescale 1ns / 1ps
module tbp_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one registered read port; read data holds while re is low
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata <= mem[raddr];
	end

endmodule

/* rtl/tournament_branch_predictor.sv */
// Tournament branch predictor: each request carries one resolved branch (PC and
// actual direction) and returns one response with the local, global and chosen
// predictions made before the tables are trained. A request goes through the
// per-PC history and global-table read, the dependent local-counter read, then
// the write-back of all tables together with the response, which waits until
// the output register is free; one request is in work at a time, and a response
// waits in an output register without holding the next request back from being
// accepted. After reset the block sweeps all tables to their reset values
// before req_ready first rises.
`timescale 1ns / 1ps
`include "tournament_branch_predictor_assert.svh"
module tournament_branch_predictor #(
	parameter int GHR_WIDTH  = tbp_pkg::GHR_WIDTH,
	parameter int LHR_WIDTH  = tbp_pkg::LHR_WIDTH,
	parameter int SLOT_WIDTH = tbp_pkg::SLOT_WIDTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  tbp_pkg::tbp_req_t req,
	output logic              resp_valid,
	input  logic              resp_ready,
	output tbp_pkg::tbp_resp_t resp
);
	import tbp_pkg::*;

	localparam int G = GHR_WIDTH;
	localparam int L = LHR_WIDTH;
	localparam int P = SLOT_WIDTH;
	localparam int GL_MAX = (G > L) ? G : L;
	localparam int CLR_BITS = (GL_MAX > P) ? GL_MAX : P;

	tbp_state_t state_q, state_d;
	logic [CLR_BITS-1:0] clr_q;
	logic [G-1:0] path_q;
	logic [P-1:0] pc_slot_q;
	logic         taken_q;
	logic         resp_valid_q;
	tbp_resp_t    resp_q;

	// Global counter [1:0] and chooser [3:2] share one table
	logic         gc_we, gc_re;
	logic [G-1:0] gc_waddr, gc_raddr;
	logic [3:0]   gc_wdata, gc_rdata;
	logic         hist_we, hist_re;
	logic [P-1:0] hist_waddr, hist_raddr;
	logic [L-1:0] hist_wdata, hist_rdata;
	logic         lc_we, lc_re;
	logic [L-1:0] lc_waddr, lc_raddr;
	logic [1:0]   lc_wdata, lc_rdata;

	logic      accept, finish;
	logic      lg, gg, use_local;
	logic [1:0] chooser_new;
	tbp_resp_t resp_d;

	tbp_ram #(.WIDTH(4), .DEPTH(2 ** G)) u_gc_ram (
		.clk(clk), .we(gc_we), .waddr(gc_waddr), .wdata(gc_wdata),
		.re(gc_re), .raddr(gc_raddr), .rdata(gc_rdata)
	);

	tbp_ram #(.WIDTH(L), .DEPTH(2 ** P)) u_hist_ram (
		.clk(clk), .we(hist_we), .waddr(hist_waddr), .wdata(hist_wdata),
		.re(hist_re), .raddr(hist_raddr), .rdata(hist_rdata)
	);

	tbp_ram #(.WIDTH(2), .DEPTH(2 ** L)) u_lc_ram (
		.clk(clk), .we(lc_we), .waddr(lc_waddr), .wdata(lc_wdata),
		.re(lc_re), .raddr(lc_raddr), .rdata(lc_rdata)
	);

	// Predictions from the read data
	assign lg        = lc_rdata >= 2'd2;
	assign gg        = gc_rdata[1:0] >= 2'd2;
	assign use_local = gc_rdata[3:2] >= 2'd2;
	assign chooser_new = (lg != gg) ? sat_move(gc_rdata[3:2], lg == taken_q) : gc_rdata[3:2];

	always_comb begin
		resp_d.predict_taken = use_local ? lg : gg;
		resp_d.local_guess   = lg;
		resp_d.global_guess  = gg;
	end

	assign req_ready  = (state_q == ST_IDLE);
	assign accept     = req_valid && req_ready;
	assign resp_valid = resp_valid_q;
	assign resp       = resp_q;

	// Next state and table port control
	always_comb begin
		state_d    = state_q;
		finish     = 1'b0;
		gc_we      = 1'b0;
		gc_waddr   = path_q;
		gc_wdata   = {chooser_new, sat_move(gc_rdata[1:0], taken_q)};
		gc_re      = 1'b0;
		gc_raddr   = path_q;
		hist_we    = 1'b0;
		hist_waddr = pc_slot_q;
		hist_wdata = L'({hist_rdata, taken_q});
		hist_re    = 1'b0;
		hist_raddr = req.branch_pc[P-1:0];
		lc_we      = 1'b0;
		lc_waddr   = hist_rdata;
		lc_wdata   = sat_move(lc_rdata, taken_q);
		lc_re      = 1'b0;
		lc_raddr   = hist_rdata;
		unique case (state_q)
			ST_CLEAR: begin
				gc_we      = 1'b1;
				gc_waddr   = clr_q[G-1:0];
				gc_wdata   = {CTR_RESET, CTR_RESET};
				hist_we    = 1'b1;
				hist_waddr = clr_q[P-1:0];
				hist_wdata = '0;
				lc_we      = 1'b1;
				lc_waddr   = clr_q[L-1:0];
				lc_wdata   = CTR_RESET;
				if (&clr_q) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				gc_re   = accept;
				hist_re = accept;
				if (accept) state_d = ST_RD1;
			end
			ST_RD1: begin
				lc_re   = 1'b1;
				state_d = ST_RD2;
			end
			ST_RD2: begin
				// Train and respond once the output register is free
				if (!resp_valid_q || resp_ready) begin
					finish  = 1'b1;
					gc_we   = 1'b1;
					hist_we = 1'b1;
					lc_we   = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_q        <= '0;
			path_q       <= '0;
			resp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + CLR_BITS'(1);
			if (finish) path_q <= G'({path_q, taken_q});
			if (finish) resp_valid_q <= 1'b1;
			else if (resp_ready) resp_valid_q <= 1'b0;
		end
	end

	// Request and response payload
	always_ff @(posedge clk) begin
		if (accept) begin
			pc_slot_q <= req.branch_pc[P-1:0];
			taken_q   <= req.taken;
		end
		if (finish) resp_q <= resp_d;
	end

	`TBP_ASSERT_NXT(a_accept_reads, accept, state_q == ST_RD1)
	`TBP_ASSERT_NXT(a_finish_resp, finish, resp_valid && state_q == ST_IDLE)
	`TBP_ASSERT_IMP(a_clear_quiet, state_q == ST_CLEAR, !resp_valid && !gc_re && !lc_re)

endmodule
